>>> rtl/low_pulse_occupancy_meter_top_macros.svh
// Assertion macros shared by the low pulse occupancy meter RTL.
`ifndef LOW_PULSE_OCCUPANCY_METER_TOP_MACROS_SVH
`define LOW_PULSE_OCCUPANCY_METER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LPOM_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LPOM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpom_pkg.sv
// Package with types and constants of the low pulse occupancy meter.
package lpom_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int TOTAL_W = TIME_W + 1;
    localparam int RATIO_W = 17;
    localparam int CNT_W   = $clog2(TIME_W);

    // Bit position of the last serial step over a time word
    localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(TIME_W - 1);

    // Divider: one integer quotient bit plus sixteen fraction bits
    localparam int DIV_STEPS = RATIO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
    // Partial remainder stays below twice the largest total
    localparam int DIV_REM_W = TOTAL_W + 1;

    // Operation codes
    localparam logic [1:0] OP_PIN     = 2'd0;
    localparam logic [1:0] OP_CLOSE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] time_us;
        logic              pin_level;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0]  low_time;
        logic [TIME_W-1:0]  high_time;
        logic [TOTAL_W-1:0] total_time;
        logic [TIME_W-1:0]  edge_count;
        logic [RATIO_W-1:0] low_ratio;
    } t_out_item;

    // Control from the sequencer to the serial accumulator datapath
    typedef struct packed {
        logic load;      // capture timestamp, preset carries
        logic restart;   // clear accumulators, take timestamp as last change
        logic clear;     // clear accumulators after a window result
        logic acc_step;  // one bit of elapsed-time accumulate
        logic tot_step;  // one bit of low + high sum
        logic bit_last;  // current step handles the top bit
        logic to_low;    // elapsed time goes to the low accumulator
        logic inc_edge;  // count a rising edge in this pass
    } t_acc_ctrl;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_TOT  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_PUSH = 5'b10000
    } t_state;

endpackage

>>> rtl/low_pulse_occupancy_meter_top.sv
// Top level of the low pulse occupancy meter: sequencer, output register, assertions.
//
//   Channel  Direction  Handshake                Payload
//   event    in         i_in_valid / o_in_ready  i_in_item  (lpom_pkg::t_in_item)
//   result   out        o_out_valid / i_out_ready o_out_item (lpom_pkg::t_out_item)
//
// Pin change to a new level: transfer, then 32 bit-serial accumulate steps.
// Same-level pin event, restart and unused opcode: handled in the transfer cycle itself.
// Window close: transfer, 32 accumulate steps, 32 total-sum steps, divider start, 17 divider
// steps and the output load, which waits in the push state while the output register is full.
// Reset is synchronous, active low; no clearing pass is needed.
// A waiting result sits in the output register while the next event is taken.
`include "low_pulse_occupancy_meter_top_macros.svh"

module low_pulse_occupancy_meter_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  lpom_pkg::t_in_item      i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output lpom_pkg::t_out_item     o_out_item
);

    lpom_pkg::t_state               r_state, n_state;
    logic [lpom_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_line, n_line;
    logic                           r_tgt_low, n_tgt_low;
    logic                           r_is_close, n_is_close;
    logic                           r_div_go, n_div_go;
    logic                           r_out_valid, n_out_valid;
    lpom_pkg::t_out_item            r_out, n_out;

    lpom_pkg::t_acc_ctrl            acc_ctrl;
    logic [lpom_pkg::TIME_W-1:0]    acc_low;
    logic [lpom_pkg::TIME_W-1:0]    acc_high;
    logic [lpom_pkg::TIME_W-1:0]    acc_edge;
    logic [lpom_pkg::TOTAL_W-1:0]   acc_total;
    logic                           div_done;
    logic [lpom_pkg::RATIO_W-1:0]   div_quot;
    logic                           in_fire;
    logic                           tot_zero;

    lpom_serial_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_time_us (i_in_item.time_us),
        .o_low     (acc_low),
        .o_high    (acc_high),
        .o_edge    (acc_edge),
        .o_total   (acc_total)
    );

    lpom_ratio_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (acc_low),
        .i_divisor  (acc_total),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_in_ready = (r_state == lpom_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign tot_zero   = (acc_total == '0);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_line      = r_line;
        n_tgt_low   = r_tgt_low;
        n_is_close  = r_is_close;
        n_div_go    = 1'b0;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        acc_ctrl          = '0;
        acc_ctrl.to_low   = r_tgt_low;
        acc_ctrl.bit_last = (r_cnt == lpom_pkg::BIT_LAST);

        // drop the result once transferred
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lpom_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (i_in_item.opcode)
                        lpom_pkg::OP_PIN: begin
                            if (i_in_item.pin_level != r_line) begin
                                // leaving low is a rising edge
                                acc_ctrl.load     = 1'b1;
                                acc_ctrl.inc_edge = i_in_item.pin_level;
                                n_tgt_low         = i_in_item.pin_level;
                                n_is_close        = 1'b0;
                                n_line            = i_in_item.pin_level;
                                n_state           = lpom_pkg::ST_ACC;
                            end
                        end
                        lpom_pkg::OP_CLOSE: begin
                            acc_ctrl.load = 1'b1;
                            n_tgt_low     = ~r_line;
                            n_is_close    = 1'b1;
                            n_line        = i_in_item.pin_level;
                            n_state       = lpom_pkg::ST_ACC;
                        end
                        lpom_pkg::OP_RESTART: begin
                            acc_ctrl.restart = 1'b1;
                            n_line           = i_in_item.pin_level;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lpom_pkg::ST_ACC: begin
                acc_ctrl.acc_step = 1'b1;
                n_cnt = r_cnt + lpom_pkg::CNT_W'(1);
                if (acc_ctrl.bit_last) begin
                    n_cnt   = '0;
                    n_state = r_is_close ? lpom_pkg::ST_TOT : lpom_pkg::ST_IDLE;
                end
            end
            lpom_pkg::ST_TOT: begin
                acc_ctrl.tot_step = 1'b1;
                n_cnt = r_cnt + lpom_pkg::CNT_W'(1);
                if (acc_ctrl.bit_last) begin
                    n_cnt    = '0;
                    n_div_go = 1'b1;
                    n_state  = lpom_pkg::ST_DIV;
                end
            end
            lpom_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = lpom_pkg::ST_PUSH;
                end
            end
            lpom_pkg::ST_PUSH: begin
                // load the output register once it is free, then clear the window
                if (!r_out_valid || i_out_ready) begin
                    n_out.low_time   = acc_low;
                    n_out.high_time  = acc_high;
                    n_out.total_time = acc_total;
                    n_out.edge_count = acc_edge;
                    n_out.low_ratio  = tot_zero ? '0 : div_quot;
                    n_out_valid      = 1'b1;
                    acc_ctrl.clear   = 1'b1;
                    n_state          = lpom_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpom_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpom_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_line      <= 1'b1;
            r_tgt_low   <= 1'b0;
            r_is_close  <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_line      <= n_line;
            r_tgt_low   <= n_tgt_low;
            r_is_close  <= n_is_close;
            r_div_go    <= n_div_go;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `LPOM_ASSERT_NEXT(a_pin_pass_ends_idle,
        (r_state == lpom_pkg::ST_ACC) && acc_ctrl.bit_last && !r_is_close,
        r_state == lpom_pkg::ST_IDLE, "pin change pass did not return to idle")
    `LPOM_ASSERT_SAME(a_div_done_in_div,
        div_done, r_state == lpom_pkg::ST_DIV, "divider finished outside divide state")
    `LPOM_ASSERT_NEXT(a_push_loads_result,
        (r_state == lpom_pkg::ST_PUSH) && (!r_out_valid || i_out_ready),
        r_out_valid && (r_state == lpom_pkg::ST_IDLE), "result not loaded on push")
    `LPOM_ASSERT_SAME(a_idle_count_zero,
        r_state == lpom_pkg::ST_IDLE, r_cnt == '0, "bit counter not at zero in idle")

endmodule

>>> rtl/lpom_serial_acc.sv
// Bit-serial accumulator datapath: elapsed time, saturating sums, edge count, total.
module lpom_serial_acc (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpom_pkg::t_acc_ctrl             i_ctrl,
    input  logic [lpom_pkg::TIME_W-1:0]     i_time_us,
    output logic [lpom_pkg::TIME_W-1:0]     o_low,
    output logic [lpom_pkg::TIME_W-1:0]     o_high,
    output logic [lpom_pkg::TIME_W-1:0]     o_edge,
    output logic [lpom_pkg::TOTAL_W-1:0]    o_total
);

    logic [lpom_pkg::TIME_W-1:0] r_now, n_now;
    logic [lpom_pkg::TIME_W-1:0] r_last, n_last;
    logic [lpom_pkg::TIME_W-1:0] r_low, n_low;
    logic [lpom_pkg::TIME_W-1:0] r_high, n_high;
    logic [lpom_pkg::TIME_W-1:0] r_edge, n_edge;
    logic [lpom_pkg::TIME_W-1:0] r_tsum, n_tsum;
    logic r_borrow, n_borrow;
    logic r_carry, n_carry;
    logic r_ecarry, n_ecarry;
    logic r_tc, n_tc;

    logic d_bit, d_borrow;
    logic tgt_bit, s_bit, s_carry;
    logic e_bit, e_carry;
    logic t_bit, t_carry;
    logic [lpom_pkg::TIME_W-1:0] acc_next;
    logic [lpom_pkg::TIME_W-1:0] edge_next;

    // One-bit slices: subtract, accumulate, increment, total
    always_comb begin
        d_bit    = r_now[0] ^ r_last[0] ^ r_borrow;
        d_borrow = (~r_now[0] & r_last[0]) | (~(r_now[0] ^ r_last[0]) & r_borrow);
        tgt_bit  = i_ctrl.to_low ? r_low[0] : r_high[0];
        s_bit    = tgt_bit ^ d_bit ^ r_carry;
        s_carry  = (tgt_bit & d_bit) | (tgt_bit & r_carry) | (d_bit & r_carry);
        e_bit    = r_edge[0] ^ r_ecarry;
        e_carry  = r_edge[0] & r_ecarry;
        t_bit    = r_low[0] ^ r_high[0] ^ r_tc;
        t_carry  = (r_low[0] & r_high[0]) | (r_low[0] & r_tc) | (r_high[0] & r_tc);
    end

    // Saturate on carry out of the top bit
    always_comb begin
        acc_next  = (i_ctrl.bit_last && s_carry) ? '1 : {s_bit, (i_ctrl.to_low ?
                    r_low[lpom_pkg::TIME_W-1:1] : r_high[lpom_pkg::TIME_W-1:1])};
        edge_next = (i_ctrl.bit_last && e_carry) ? '1 :
                    {e_bit, r_edge[lpom_pkg::TIME_W-1:1]};
    end

    // Next-state selection
    always_comb begin
        n_now    = r_now;
        n_last   = r_last;
        n_low    = r_low;
        n_high   = r_high;
        n_edge   = r_edge;
        n_tsum   = r_tsum;
        n_borrow = r_borrow;
        n_carry  = r_carry;
        n_ecarry = r_ecarry;
        n_tc     = r_tc;
        if (i_ctrl.restart) begin
            n_low  = '0;
            n_high = '0;
            n_edge = '0;
            n_last = i_time_us;
        end else if (i_ctrl.clear) begin
            n_low  = '0;
            n_high = '0;
            n_edge = '0;
        end else if (i_ctrl.load) begin
            n_now    = i_time_us;
            n_borrow = 1'b0;
            n_carry  = 1'b0;
            n_ecarry = i_ctrl.inc_edge;
            n_tc     = 1'b0;
        end else if (i_ctrl.acc_step) begin
            // shift the timestamp into last so it ends the pass as the new change time
            n_now    = {r_now[0], r_now[lpom_pkg::TIME_W-1:1]};
            n_last   = {r_now[0], r_last[lpom_pkg::TIME_W-1:1]};
            n_borrow = d_borrow;
            n_carry  = s_carry;
            n_ecarry = e_carry;
            n_edge   = edge_next;
            if (i_ctrl.to_low) begin
                n_low  = acc_next;
                n_high = {r_high[0], r_high[lpom_pkg::TIME_W-1:1]};
            end else begin
                n_high = acc_next;
                n_low  = {r_low[0], r_low[lpom_pkg::TIME_W-1:1]};
            end
        end else if (i_ctrl.tot_step) begin
            // rotate both accumulators back to themselves, sum into total
            n_low  = {r_low[0], r_low[lpom_pkg::TIME_W-1:1]};
            n_high = {r_high[0], r_high[lpom_pkg::TIME_W-1:1]};
            n_tsum = {t_bit, r_tsum[lpom_pkg::TIME_W-1:1]};
            n_tc   = t_carry;
        end
    end

    // Accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_low  <= '0;
            r_high <= '0;
            r_edge <= '0;
        end else begin
            r_last <= n_last;
            r_low  <= n_low;
            r_high <= n_high;
            r_edge <= n_edge;
        end
    end

    // Serial working registers
    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_tsum   <= n_tsum;
        r_borrow <= n_borrow;
        r_carry  <= n_carry;
        r_ecarry <= n_ecarry;
        r_tc     <= n_tc;
    end

    assign o_low   = r_low;
    assign o_high  = r_high;
    assign o_edge  = r_edge;
    assign o_total = {r_tc, r_tsum};

endmodule

>>> rtl/lpom_ratio_div.sv
// Radix-2 restoring divider for the low/total ratio, one quotient bit per cycle.
module lpom_ratio_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [lpom_pkg::TIME_W-1:0]     i_dividend,
    input  logic [lpom_pkg::TOTAL_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [lpom_pkg::RATIO_W-1:0]    o_quot
);

    logic                                  r_busy, n_busy;
    logic [lpom_pkg::DIV_CNT_W-1:0]        r_cnt, n_cnt;
    logic [lpom_pkg::DIV_REM_W-1:0]        r_rem, n_rem;
    logic [lpom_pkg::RATIO_W-1:0]          r_q, n_q;
    logic [lpom_pkg::DIV_REM_W:0]          diff;
    logic                                  ge;
    logic [lpom_pkg::DIV_REM_W-1:0]        rem_after;

    // Trial subtract; the partial remainder stays below twice the divisor
    always_comb begin
        diff      = {1'b0, r_rem} - {2'b00, i_divisor};
        ge        = ~diff[lpom_pkg::DIV_REM_W];
        rem_after = ge ? diff[lpom_pkg::DIV_REM_W-1:0] : r_rem;
    end

    assign o_done = r_busy && (r_cnt == lpom_pkg::DIV_LAST);

    // Step control
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_start) begin
            // low never exceeds total, so the first step yields the integer bit
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = lpom_pkg::DIV_REM_W'(i_dividend);
            n_q    = '0;
        end else if (r_busy) begin
            n_rem = {rem_after[lpom_pkg::DIV_REM_W-2:0], 1'b0};
            n_q   = {r_q[lpom_pkg::RATIO_W-2:0], ge};
            n_cnt = r_cnt + lpom_pkg::DIV_CNT_W'(1);
            if (o_done) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_quot = r_q;

endmodule
